// File: hdl/assert_macros.svh
// Assertion macros shared by the lowest-common-ancestor engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tlca_pkg.sv
// Shared types and constants for the binary-lifting ancestor engine.
package tlca_pkg;

    localparam int NODE_W      = 11;
    localparam int REQ_W       = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;
    localparam int DSUM_W      = 15;

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_LEVELS    = 10;

    localparam logic [NODE_W-1:0] ROOT_NODE      = 11'd1;
    localparam logic [NODE_W-1:0] NODE_COUNT_RST = 11'd1;
    localparam logic [NODE_W-1:0] PATH_MAX       = 11'h7FF;

    // Query runs three ancestor searches: (a,c), (a,root), (root,c)
    localparam logic [1:0] PASS_AC   = 2'd0;
    localparam logic [1:0] PASS_A1   = 2'd1;
    localparam logic [1:0] PASS_LAST = 2'd2;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_BUILD = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAP,
        OP_LOAD,
        OP_B_INIT,
        OP_B_RD1,
        OP_B_RD2,
        OP_B_WR,
        OP_Q_INIT,
        OP_Q_DEP,
        OP_Q_SWAP,
        OP_P1_ANC,
        OP_P1_DEP,
        OP_P1_CMP,
        OP_EQ,
        OP_P2_ANC,
        OP_P2_CMP,
        OP_FIN_RD,
        OP_FIN_SET,
        OP_NEXT,
        OP_DL1,
        OP_DL2,
        OP_DL3,
        OP_SUM,
        OP_PUSH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic q_ok;
        logic bld_ok;
        logic lvl_zero;
        logic bld_last;
        logic u_eq_v;
        logic pass_last;
        logic out_free;
    } t_stat;

endpackage

// File: hdl/tlca_dp.sv
// Datapath: ancestor and depth memories, search registers, result and output register.
`include "assert_macros.svh"

module tlca_dp #(
    parameter int MAX_NODES = tlca_pkg::DEF_MAX_NODES,
    parameter int LEVELS    = tlca_pkg::DEF_LEVELS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tlca_pkg::NODE_W-1:0]          i_cfg_wdata,
    input  logic [tlca_pkg::IN_TDATA_W-1:0]      i_tdata,
    input  logic [tlca_pkg::REQ_W-1:0]           i_tuser,
    input  tlca_pkg::t_cmd                       i_cmd,
    output tlca_pkg::t_stat                      o_stat,
    input  logic                                 i_m_tready,
    output logic                                 o_m_tvalid,
    output logic [tlca_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    localparam int NW        = $clog2(MAX_NODES + 1);
    localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int AW        = NW + LW;
    localparam int ANC_DEPTH = (MAX_NODES + 1) << LW;
    localparam int DEP_DEPTH = MAX_NODES + 1;
    localparam int W         = tlca_pkg::NODE_W;
    localparam int SW        = tlca_pkg::DSUM_W;
    localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

    // Configuration and captured request
    logic [W-1:0]     r_node_count;
    tlca_pkg::t_req   r_req;
    logic [W-1:0]     r_na, r_nb, r_din;

    // Search state
    logic [W-1:0]     r_u, r_v, r_t, r_du;
    logic [LW-1:0]    r_lvl;
    logic [W-1:0]     r_i;
    logic [LW-1:0]    r_j;
    logic [1:0]       r_pass;
    logic [W-1:0]     r_l_ac, r_l_a1, r_l_1c;
    logic [W-1:0]     r_da, r_dc, r_d1, r_dl_ac, r_dl_a1, r_dl_1c;

    // Result and output register
    logic [W-1:0]     r_res_lca, r_res_path;
    logic             r_res_on;
    logic             r_m_tvalid;
    logic [tlca_pkg::OUT_TDATA_W-1:0] r_m_tdata;

    // Memories and registered read ports
    logic [W-1:0]     r_anc_mem [ANC_DEPTH];
    logic [W-1:0]     r_dep_mem [DEP_DEPTH];
    logic [W-1:0]     r_anc_qa, r_anc_qb, r_dep_qa, r_dep_qb;
    logic             r_anc_za, r_anc_zb, r_dep_za, r_dep_zb;

    logic [W-1:0]     lim;
    logic [W-1:0]     anc_a, anc_b, dep_a, dep_b;
    logic [W-1:0]     anc_ra_n, anc_rb_n, dep_ra_n, dep_rb_n;
    logic [LW-1:0]    anc_ra_l, anc_rb_l;
    logic             anc_we, dep_we;
    logic [AW-1:0]    anc_wa;
    logic [W-1:0]     anc_wd;
    logic             load_ok;
    logic [W-1:0]     nb_fix;
    logic [W-1:0]     lca_pick;
    logic             lca_set;
    logic signed [SW-1:0] d_ac, d_a1, d_1c;
    logic [W-1:0]     path_sat;

    function automatic logic f_oob(input logic [W-1:0] n);
        return (n == '0) || (32'(n) > MAX_NODES);
    endfunction

    function automatic logic [AW-1:0] f_anc_addr(input logic [W-1:0] n,
                                                 input logic [LW-1:0] l);
        return {NW'(n), l};
    endfunction

    function automatic logic f_in_range(input logic [W-1:0] n, input logic [W-1:0] lm);
        return (n != '0) && (n <= lm);
    endfunction

    function automatic logic signed [SW-1:0] f_sx(input logic [W-1:0] d);
        return $signed({{(SW - W){1'b0}}, d});
    endfunction

    // Usable node limit
    always_comb begin
        if (32'(r_node_count) < MAX_NODES) begin
            lim = r_node_count;
        end else begin
            lim = W'(MAX_NODES);
        end
    end

    // Read data with node zero and out-of-range nodes reading as zero
    assign anc_a = r_anc_za ? '0 : r_anc_qa;
    assign anc_b = r_anc_zb ? '0 : r_anc_qb;
    assign dep_a = r_dep_za ? '0 : r_dep_qa;
    assign dep_b = r_dep_zb ? '0 : r_dep_qb;

    assign load_ok = f_in_range(r_na, lim);
    assign nb_fix  = ((r_nb == '0) || (r_nb > lim)) ? tlca_pkg::ROOT_NODE : r_nb;

    // Select read addresses for the current step
    always_comb begin
        anc_ra_n = '0;
        anc_ra_l = '0;
        anc_rb_n = '0;
        anc_rb_l = '0;
        dep_ra_n = '0;
        dep_rb_n = '0;
        case (i_cmd.op)
            tlca_pkg::OP_B_RD1: begin
                anc_ra_n = r_i;
                anc_ra_l = r_j - 1'b1;
            end
            tlca_pkg::OP_B_RD2: begin
                anc_ra_n = anc_a;
                anc_ra_l = r_j - 1'b1;
            end
            tlca_pkg::OP_Q_DEP: begin
                dep_ra_n = r_u;
                dep_rb_n = r_v;
            end
            tlca_pkg::OP_P1_ANC: begin
                anc_ra_n = r_v;
                anc_ra_l = r_lvl;
            end
            tlca_pkg::OP_P1_DEP: begin
                dep_ra_n = anc_a;
            end
            tlca_pkg::OP_P2_ANC: begin
                anc_ra_n = r_u;
                anc_ra_l = r_lvl;
                anc_rb_n = r_v;
                anc_rb_l = r_lvl;
            end
            tlca_pkg::OP_FIN_RD: begin
                anc_ra_n = r_v;
            end
            tlca_pkg::OP_DL1: begin
                dep_ra_n = r_l_ac;
                dep_rb_n = r_l_a1;
            end
            tlca_pkg::OP_DL2: begin
                dep_ra_n = r_l_1c;
            end
            default: begin
            end
        endcase
    end

    // Write port selection: node load or table build
    always_comb begin
        anc_we = 1'b0;
        dep_we = 1'b0;
        anc_wa = f_anc_addr(r_na, '0);
        anc_wd = nb_fix;
        case (i_cmd.op)
            tlca_pkg::OP_LOAD: begin
                anc_we = load_ok;
                dep_we = load_ok;
            end
            tlca_pkg::OP_B_WR: begin
                anc_we = 1'b1;
                anc_wa = f_anc_addr(r_i, r_j);
                anc_wd = (anc_a == '0) ? tlca_pkg::ROOT_NODE : anc_a;
            end
            default: begin
            end
        endcase
    end

    // Ancestor memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (anc_we) begin
            r_anc_mem[anc_wa] <= anc_wd;
        end
        r_anc_qa <= r_anc_mem[f_anc_addr(anc_ra_n, anc_ra_l)];
        r_anc_qb <= r_anc_mem[f_anc_addr(anc_rb_n, anc_rb_l)];
        r_anc_za <= f_oob(anc_ra_n);
        r_anc_zb <= f_oob(anc_rb_n);
    end

    // Depth memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (dep_we) begin
            r_dep_mem[NW'(r_na)] <= r_din;
        end
        r_dep_qa <= r_dep_mem[NW'(dep_ra_n)];
        r_dep_qb <= r_dep_mem[NW'(dep_rb_n)];
        r_dep_za <= f_oob(dep_ra_n);
        r_dep_zb <= f_oob(dep_rb_n);
    end

    // Ancestor found by the current pass
    always_comb begin
        lca_set  = 1'b0;
        lca_pick = r_u;
        case (i_cmd.op)
            tlca_pkg::OP_EQ: begin
                lca_set  = (r_u == r_v);
                lca_pick = r_u;
            end
            tlca_pkg::OP_FIN_SET: begin
                lca_set  = 1'b1;
                lca_pick = anc_a;
            end
            default: begin
            end
        endcase
    end

    // Edge counts and saturated path length
    always_comb begin
        d_ac = f_sx(r_da) + f_sx(r_dc) - f_sx(r_dl_ac) - f_sx(r_dl_ac);
        d_a1 = f_sx(r_da) + f_sx(r_d1) - f_sx(r_dl_a1) - f_sx(r_dl_a1);
        d_1c = f_sx(r_d1) + f_sx(r_dc) - f_sx(r_dl_1c) - f_sx(r_dl_1c);
        if (d_ac < 0) begin
            path_sat = '0;
        end else if (d_ac > f_sx(tlca_pkg::PATH_MAX)) begin
            path_sat = tlca_pkg::PATH_MAX;
        end else begin
            path_sat = d_ac[W-1:0];
        end
    end

    // Search and result registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            tlca_pkg::OP_CAP: begin
                r_req      <= tlca_pkg::t_req'(i_tuser);
                r_na       <= i_tdata[W-1:0];
                r_nb       <= i_tdata[2*W-1:W];
                r_din      <= i_tdata[3*W-1:2*W];
                r_res_lca  <= '0;
                r_res_path <= '0;
                r_res_on   <= 1'b0;
                r_pass     <= tlca_pkg::PASS_AC;
            end
            tlca_pkg::OP_B_INIT: begin
                r_i <= tlca_pkg::ROOT_NODE;
                r_j <= LW'(1);
            end
            tlca_pkg::OP_B_WR: begin
                if (r_i == lim) begin
                    r_i <= tlca_pkg::ROOT_NODE;
                    r_j <= r_j + 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            tlca_pkg::OP_Q_INIT: begin
                case (r_pass)
                    tlca_pkg::PASS_AC: begin
                        r_u <= r_na;
                        r_v <= r_nb;
                    end
                    tlca_pkg::PASS_A1: begin
                        r_u <= r_na;
                        r_v <= tlca_pkg::ROOT_NODE;
                    end
                    default: begin
                        r_u <= tlca_pkg::ROOT_NODE;
                        r_v <= r_nb;
                    end
                endcase
            end
            tlca_pkg::OP_Q_SWAP: begin
                if (r_pass == tlca_pkg::PASS_AC) begin
                    r_da <= dep_a;
                    r_dc <= dep_b;
                end
                if (r_pass == tlca_pkg::PASS_A1) begin
                    r_d1 <= dep_b;
                end
                // keep u as the shallower node
                if (dep_a > dep_b) begin
                    r_u  <= r_v;
                    r_v  <= r_u;
                    r_du <= dep_b;
                end else begin
                    r_du <= dep_a;
                end
            end
            tlca_pkg::OP_P1_DEP: begin
                r_t <= anc_a;
            end
            tlca_pkg::OP_P1_CMP: begin
                if (dep_a >= r_du) begin
                    r_v <= r_t;
                end
            end
            tlca_pkg::OP_P2_CMP: begin
                if (anc_a != anc_b) begin
                    r_u <= anc_a;
                    r_v <= anc_b;
                end
            end
            tlca_pkg::OP_NEXT: begin
                r_pass <= r_pass + 1'b1;
            end
            tlca_pkg::OP_DL2: begin
                r_dl_ac <= dep_a;
                r_dl_a1 <= dep_b;
            end
            tlca_pkg::OP_DL3: begin
                r_dl_1c <= dep_a;
            end
            tlca_pkg::OP_SUM: begin
                r_res_lca  <= r_l_ac;
                r_res_path <= path_sat;
                r_res_on   <= ((d_1c + d_ac) == d_a1);
            end
            default: begin
            end
        endcase
        // store the ancestor of the finished pass
        if (lca_set) begin
            case (r_pass)
                tlca_pkg::PASS_AC: r_l_ac <= lca_pick;
                tlca_pkg::PASS_A1: r_l_a1 <= lca_pick;
                default:           r_l_1c <= lca_pick;
            endcase
        end
    end

    // Level counter steps down and wraps to the top level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl <= LVL_TOP;
        end else begin
            case (i_cmd.op)
                tlca_pkg::OP_Q_INIT: r_lvl <= LVL_TOP;
                tlca_pkg::OP_P1_CMP,
                tlca_pkg::OP_P2_CMP: begin
                    if (r_lvl == '0) begin
                        r_lvl <= LVL_TOP;
                    end else begin
                        r_lvl <= r_lvl - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Node count register and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= tlca_pkg::NODE_COUNT_RST;
            r_m_tvalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            if (i_cmd.op == tlca_pkg::OP_PUSH) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == tlca_pkg::OP_PUSH) begin
            r_m_tdata <= {1'b0, r_res_on, r_res_path, r_res_lca};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    // Status back to the controller
    always_comb begin
        o_stat.req       = r_req;
        o_stat.q_ok      = f_in_range(r_na, lim) && f_in_range(r_nb, lim);
        o_stat.bld_ok    = (lim != '0) && (LEVELS > 1);
        o_stat.lvl_zero  = (r_lvl == '0);
        o_stat.bld_last  = (r_i == lim) && (r_j == LVL_TOP);
        o_stat.u_eq_v    = (r_u == r_v);
        o_stat.pass_last = (r_pass == tlca_pkg::PASS_LAST);
        o_stat.out_free  = !r_m_tvalid || i_m_tready;
    end

    `ASSERT_IMPL(a_bld_node_valid, i_clk, i_rst_n, i_cmd.op == tlca_pkg::OP_B_WR, (r_i != '0) && (r_i <= lim), "build writes a node outside the usable range")
    `ASSERT_IMPL(a_push_no_overwrite, i_clk, i_rst_n, i_cmd.op == tlca_pkg::OP_PUSH, !r_m_tvalid || i_m_tready, "result pushed over an untaken result")
    `ASSERT_IMPL(a_lvl_range, i_clk, i_rst_n, 1'b1, r_lvl <= LVL_TOP, "lifting level beyond table height")

endmodule

// File: hdl/tlca_ctrl.sv
// Controller: sequences load, table build and three-pass query steps.
`include "assert_macros.svh"

module tlca_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  tlca_pkg::t_stat i_stat,
    output tlca_pkg::t_cmd  o_cmd
);

    typedef enum logic [23:0] {
        S_IDLE    = 24'h000001,
        S_DISP    = 24'h000002,
        S_LOAD    = 24'h000004,
        S_B_INIT  = 24'h000008,
        S_B_RD1   = 24'h000010,
        S_B_RD2   = 24'h000020,
        S_B_WR    = 24'h000040,
        S_Q_INIT  = 24'h000080,
        S_Q_DEP   = 24'h000100,
        S_Q_SWAP  = 24'h000200,
        S_P1_ANC  = 24'h000400,
        S_P1_DEP  = 24'h000800,
        S_P1_CMP  = 24'h001000,
        S_EQ      = 24'h002000,
        S_P2_ANC  = 24'h004000,
        S_P2_CMP  = 24'h008000,
        S_FIN_RD  = 24'h010000,
        S_FIN_SET = 24'h020000,
        S_NEXT    = 24'h040000,
        S_DL1     = 24'h080000,
        S_DL2     = 24'h100000,
        S_DL3     = 24'h200000,
        S_SUM     = 24'h400000,
        S_DONE    = 24'h800000
    } t_state;

    t_state r_state, n_state;

    // Next state and step command
    always_comb begin
        n_state   = r_state;
        o_cmd.op  = tlca_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op = tlca_pkg::OP_CAP;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.req)
                    tlca_pkg::REQ_LOAD:  n_state = S_LOAD;
                    tlca_pkg::REQ_BUILD: n_state = i_stat.bld_ok ? S_B_INIT : S_DONE;
                    tlca_pkg::REQ_QUERY: n_state = i_stat.q_ok ? S_Q_INIT : S_DONE;
                    default:             n_state = S_DONE;
                endcase
            end
            S_LOAD: begin
                o_cmd.op = tlca_pkg::OP_LOAD;
                n_state  = S_DONE;
            end
            S_B_INIT: begin
                o_cmd.op = tlca_pkg::OP_B_INIT;
                n_state  = S_B_RD1;
            end
            S_B_RD1: begin
                o_cmd.op = tlca_pkg::OP_B_RD1;
                n_state  = S_B_RD2;
            end
            S_B_RD2: begin
                o_cmd.op = tlca_pkg::OP_B_RD2;
                n_state  = S_B_WR;
            end
            S_B_WR: begin
                o_cmd.op = tlca_pkg::OP_B_WR;
                n_state  = i_stat.bld_last ? S_DONE : S_B_RD1;
            end
            S_Q_INIT: begin
                o_cmd.op = tlca_pkg::OP_Q_INIT;
                n_state  = S_Q_DEP;
            end
            S_Q_DEP: begin
                o_cmd.op = tlca_pkg::OP_Q_DEP;
                n_state  = S_Q_SWAP;
            end
            S_Q_SWAP: begin
                o_cmd.op = tlca_pkg::OP_Q_SWAP;
                n_state  = S_P1_ANC;
            end
            S_P1_ANC: begin
                o_cmd.op = tlca_pkg::OP_P1_ANC;
                n_state  = S_P1_DEP;
            end
            S_P1_DEP: begin
                o_cmd.op = tlca_pkg::OP_P1_DEP;
                n_state  = S_P1_CMP;
            end
            S_P1_CMP: begin
                o_cmd.op = tlca_pkg::OP_P1_CMP;
                n_state  = i_stat.lvl_zero ? S_EQ : S_P1_ANC;
            end
            S_EQ: begin
                o_cmd.op = tlca_pkg::OP_EQ;
                n_state  = i_stat.u_eq_v ? S_NEXT : S_P2_ANC;
            end
            S_P2_ANC: begin
                o_cmd.op = tlca_pkg::OP_P2_ANC;
                n_state  = S_P2_CMP;
            end
            S_P2_CMP: begin
                o_cmd.op = tlca_pkg::OP_P2_CMP;
                n_state  = i_stat.lvl_zero ? S_FIN_RD : S_P2_ANC;
            end
            S_FIN_RD: begin
                o_cmd.op = tlca_pkg::OP_FIN_RD;
                n_state  = S_FIN_SET;
            end
            S_FIN_SET: begin
                o_cmd.op = tlca_pkg::OP_FIN_SET;
                n_state  = S_NEXT;
            end
            S_NEXT: begin
                o_cmd.op = tlca_pkg::OP_NEXT;
                n_state  = i_stat.pass_last ? S_DL1 : S_Q_INIT;
            end
            S_DL1: begin
                o_cmd.op = tlca_pkg::OP_DL1;
                n_state  = S_DL2;
            end
            S_DL2: begin
                o_cmd.op = tlca_pkg::OP_DL2;
                n_state  = S_DL3;
            end
            S_DL3: begin
                o_cmd.op = tlca_pkg::OP_DL3;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = tlca_pkg::OP_SUM;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.op = tlca_pkg::OP_PUSH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    `ASSERT_NEXT(a_take_drops_ready, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "input taken while a request is in progress")
    `ASSERT_NEXT(a_push_to_idle, i_clk, i_rst_n, (r_state == S_DONE) && i_stat.out_free, o_s_tready, "controller did not return to idle after a push")

endmodule

// File: hdl/tree_lca_binary_lifting_unit.sv
// Top level of the binary-lifting lowest-common-ancestor engine.
//
//  channel   | direction | handshake              | content
//  ----------+-----------+------------------------+------------------------------------------
//  s_axis    | in        | tvalid/tready          | tuser: req_type; tdata: node_a, node_b,
//            |           |                        |   depth_in
//  m_axis    | out       | tvalid/tready          | tdata: lca_node, path_length, on_root_path
//  cfg       | in        | i_cfg_we               | i_cfg_wdata: node_count
//
// One request at a time; every request yields one result transfer.
// Build reads the single ancestor memory twice per table entry, the second read depending
// on the first. Query runs three ancestor searches, each a chain of memory reads that climbs
// one lifting level per depth-climb step (ancestor, depth, compare) and per joint-climb step
// (ancestors, compare).
// Reset (synchronous, active low) clears the controller, the output valid and node_count to 1;
// the tables are undefined until loaded. A stalled output holds the next result in its last
// step; input is taken again once the result moves into the output register.
module tree_lca_binary_lifting_unit #(
    parameter int MAX_NODES = tlca_pkg::DEF_MAX_NODES,
    parameter int LEVELS    = tlca_pkg::DEF_LEVELS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tlca_pkg::NODE_W-1:0]          i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [10:0] node_a, [21:11] node_b, [32:22] depth_in, [39:33] zero
    input  logic [tlca_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [1:0] req_type
    input  logic [tlca_pkg::REQ_W-1:0]           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [10:0] lca_node, [21:11] path_length, [22] on_root_path, [23] zero
    output logic [tlca_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    tlca_pkg::t_cmd  cmd;
    tlca_pkg::t_stat stat;

    tlca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tlca_dp #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

// File: test/tb_tree_lca_binary_lifting_unit.sv
// Self-checking testbench for the binary-lifting lowest-common-ancestor engine.
module tb_tree_lca_binary_lifting_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_N          = tlca_pkg::DEF_MAX_NODES;
    localparam int LIFT_LEVELS    = tlca_pkg::DEF_LEVELS;
    localparam int RANDOM_ITEMS   = 80;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 150000;
    localparam int DRAIN_CYCLES   = 200;

    // Tree shapes used by the generator
    localparam int SHAPE_RANDOM = 0;
    localparam int SHAPE_CHAIN  = 1;
    localparam int SHAPE_STAR   = 2;
    localparam int SHAPE_HEAP   = 3;

    // Result fields in tdata order, highest bit first
    typedef struct packed {
        logic                        on_path;
        logic [tlca_pkg::NODE_W-1:0] path_len;
        logic [tlca_pkg::NODE_W-1:0] lca;
    } t_answer;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [tlca_pkg::NODE_W-1:0]        i_cfg_wdata;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    // [10:0] node_a, [21:11] node_b, [32:22] depth_in, [39:33] zero
    logic [tlca_pkg::IN_TDATA_W-1:0]    s_axis_tdata;
    // [1:0] req_type
    logic [tlca_pkg::REQ_W-1:0]         s_axis_tuser;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    // [10:0] lca_node, [21:11] path_length, [22] on_root_path, [23] zero
    logic [tlca_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;

    // Predictor state
    logic [tlca_pkg::NODE_W-1:0] lift_table [0:MAX_N][0:LIFT_LEVELS-1];
    logic [tlca_pkg::NODE_W-1:0] depth_table [0:MAX_N];
    logic [tlca_pkg::NODE_W-1:0] node_count_mdl;
    t_answer                     pending_answers [$];

    // Run control and statistics
    bit gaps_on       = 1'b1;
    bit stalls_on     = 1'b1;
    bit long_hold_req = 1'b0;
    int mismatch_count = 0;
    int work_items     = 0;
    int load_count     = 0;
    int build_count    = 0;
    int query_count    = 0;
    int nop_count      = 0;
    int settings_seen  = 0;
    int largest_count  = 0;

    tree_lca_binary_lifting_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [tlca_pkg::NODE_W-1:0] ancestor_at(
        input logic [tlca_pkg::NODE_W-1:0] n, input int lvl);
        if (n > MAX_N) return '0;
        return lift_table[n][lvl];
    endfunction

    function automatic logic [tlca_pkg::NODE_W-1:0] depth_at(
        input logic [tlca_pkg::NODE_W-1:0] n);
        if (n > MAX_N) return '0;
        return depth_table[n];
    endfunction

    function automatic logic [tlca_pkg::NODE_W-1:0] common_ancestor(
        input logic [tlca_pkg::NODE_W-1:0] x, y);
        logic [tlca_pkg::NODE_W-1:0] u, v, t;
        u = x;
        v = y;
        // lift the deeper node to the depth of the shallower one
        if (depth_at(u) > depth_at(v)) begin
            t = u;
            u = v;
            v = t;
        end
        for (int i = LIFT_LEVELS - 1; i >= 0; i--) begin
            t = ancestor_at(v, i);
            if (depth_at(t) >= depth_at(u)) v = t;
        end
        if (u == v) return u;
        // climb both while their ancestors differ
        for (int i = LIFT_LEVELS - 1; i >= 0; i--) begin
            if (ancestor_at(u, i) != ancestor_at(v, i)) begin
                t = ancestor_at(u, i);
                v = ancestor_at(v, i);
                u = t;
            end
        end
        return ancestor_at(v, 0);
    endfunction

    function automatic int edges_between(input logic [tlca_pkg::NODE_W-1:0] a, c, l);
        return (int'(depth_at(a)) - int'(depth_at(l))) +
               (int'(depth_at(c)) - int'(depth_at(l)));
    endfunction

    function automatic t_answer predict_request(input tlca_pkg::t_req req,
                                                input logic [tlca_pkg::NODE_W-1:0] a, b, dep);
        t_answer                     ans;
        int                          lim, d_ac, d_a1, d_1c;
        logic [tlca_pkg::NODE_W-1:0] t, l_ac, l_a1, l_1c;
        ans = '0;
        lim = (node_count_mdl < MAX_N) ? int'(node_count_mdl) : MAX_N;
        case (req)
            tlca_pkg::REQ_LOAD: begin
                if (a >= 1 && a <= lim) begin
                    lift_table[a][0] = (b == 0 || b > lim) ? tlca_pkg::ROOT_NODE : b;
                    depth_table[a]   = dep;
                end
            end
            tlca_pkg::REQ_BUILD: begin
                for (int j = 1; j < LIFT_LEVELS; j++) begin
                    for (int i = 1; i <= lim; i++) begin
                        t = ancestor_at(ancestor_at(tlca_pkg::NODE_W'(i), j - 1), j - 1);
                        if (t == 0) t = tlca_pkg::ROOT_NODE;
                        lift_table[i][j] = t;
                    end
                end
            end
            tlca_pkg::REQ_QUERY: begin
                if (a >= 1 && a <= lim && b >= 1 && b <= lim) begin
                    l_ac = common_ancestor(a, b);
                    l_a1 = common_ancestor(a, tlca_pkg::ROOT_NODE);
                    l_1c = common_ancestor(tlca_pkg::ROOT_NODE, b);
                    d_ac = edges_between(a, b, l_ac);
                    d_a1 = edges_between(a, tlca_pkg::ROOT_NODE, l_a1);
                    d_1c = edges_between(tlca_pkg::ROOT_NODE, b, l_1c);
                    ans.lca      = l_ac;
                    ans.path_len = (d_ac < 0) ? '0 :
                                   (d_ac > int'(tlca_pkg::PATH_MAX)) ? tlca_pkg::PATH_MAX :
                                   tlca_pkg::NODE_W'(d_ac);
                    ans.on_path  = (d_1c + d_ac == d_a1);
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Offer one request, wait for the transfer, record the expected answer
    task automatic send_req(input tlca_pkg::t_req req,
                            input logic [tlca_pkg::NODE_W-1:0] a, b, dep);
        t_answer ans;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, dep, b, a};
        s_axis_tuser  <= req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (req != tlca_pkg::REQ_NOP &&
            !(req == tlca_pkg::REQ_LOAD && (a == 0 || a > node_count_mdl)))
            work_items++;
        case (req)
            tlca_pkg::REQ_LOAD:  load_count++;
            tlca_pkg::REQ_BUILD: build_count++;
            tlca_pkg::REQ_QUERY: query_count++;
            default:             nop_count++;
        endcase
        ans = predict_request(req, a, b, dep);
        pending_answers.insert(pending_answers.size(), ans);
    endtask

    // Drop valid and wait until every answer has come back
    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_node_count(input int value);
        wait_until_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= tlca_pkg::NODE_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        node_count_mdl = tlca_pkg::NODE_W'(value);
        settings_seen++;
        if (value > largest_count) largest_count = value;
        @(posedge i_clk);
    endtask

    function automatic logic [tlca_pkg::NODE_W-1:0] any_node();
        return tlca_pkg::NODE_W'($urandom_range(0, MAX_N));
    endfunction

    function automatic logic [tlca_pkg::NODE_W-1:0] any_depth();
        return tlca_pkg::NODE_W'($urandom_range(1, MAX_N));
    endfunction

    function automatic logic [tlca_pkg::NODE_W-1:0] in_node(input int n);
        return tlca_pkg::NODE_W'($urandom_range(1, n));
    endfunction

    // Node id outside 1..n: zero, or above n when the range allows it
    function automatic logic [tlca_pkg::NODE_W-1:0] outside_node(input int n);
        if (n < MAX_N && $urandom_range(0, 1) == 1)
            return tlca_pkg::NODE_W'($urandom_range(n + 1, MAX_N));
        return '0;
    endfunction

    // Requests that are ignored or answered with zeros
    task automatic send_noise(input int n);
        case ($urandom_range(0, 3))
            0:       send_req(tlca_pkg::REQ_NOP, any_node(), any_node(), any_depth());
            1:       send_req(tlca_pkg::REQ_LOAD, outside_node(n), any_node(), any_depth());
            2:       send_req(tlca_pkg::REQ_QUERY, outside_node(n), in_node(n), any_depth());
            default: send_req(tlca_pkg::REQ_QUERY, in_node(n), outside_node(n), any_depth());
        endcase
    endtask

    // Set node_count, load a whole tree, build, then run a mix of queries
    task automatic run_tree_phase(input int n, input int shape, input int n_queries);
        int par [1:MAX_N];
        int dep [1:MAX_N];
        int order [1:MAX_N];
        int i, j, tmp, a, c;
        write_node_count(n);
        // root first: its own parent, or a bad parent that maps to the root
        case ($urandom_range(0, 2))
            0:       par[1] = 1;
            1:       par[1] = 0;
            default: par[1] = (n < MAX_N) ? $urandom_range(n + 1, MAX_N) : 1;
        endcase
        dep[1] = 1;
        for (i = 2; i <= n; i++) begin
            case (shape)
                SHAPE_CHAIN: par[i] = ($urandom_range(0, 7) == 0) ?
                                      $urandom_range(1, i - 1) : i - 1;
                SHAPE_STAR:  par[i] = ($urandom_range(0, 3) == 0) ?
                                      $urandom_range(1, i - 1) : 1;
                SHAPE_HEAP:  par[i] = i / 2;
                default:     par[i] = $urandom_range(1, i - 1);
            endcase
            dep[i] = dep[par[i]] + 1;
            if ($urandom_range(0, 19) == 0) dep[i] = $urandom_range(1, MAX_N);
            if (dep[i] > MAX_N) dep[i] = MAX_N;
            if ($urandom_range(0, 29) == 0) par[i] = outside_node(n);
        end
        // load in order or shuffled
        for (i = 1; i <= n; i++) order[i] = i;
        if ($urandom_range(0, 1) == 1) begin
            for (i = n; i >= 2; i--) begin
                j        = $urandom_range(1, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
        end
        for (i = 1; i <= n; i++) begin
            if ($urandom_range(0, 15) == 0) send_noise(n);
            send_req(tlca_pkg::REQ_LOAD, tlca_pkg::NODE_W'(order[i]),
                     tlca_pkg::NODE_W'(par[order[i]]), tlca_pkg::NODE_W'(dep[order[i]]));
        end
        send_req(tlca_pkg::REQ_BUILD, any_node(), any_node(), any_depth());
        for (i = 0; i < n_queries; i++) begin
            case ($urandom_range(0, 19))
                0: send_noise(n);
                1: send_req(tlca_pkg::REQ_BUILD, any_node(), any_node(), any_depth());
                2: send_req(tlca_pkg::REQ_LOAD, in_node(n), any_node(), any_depth());
                default: begin
                    a = $urandom_range(1, n);
                    case ($urandom_range(0, 7))
                        0:       c = a;
                        1:       c = 1;
                        default: c = $urandom_range(1, n);
                    endcase
                    send_req(tlca_pkg::REQ_QUERY, tlca_pkg::NODE_W'(a), tlca_pkg::NODE_W'(c),
                             any_depth());
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Single-node tree: ignored loads, no-op, out-of-range queries, root-only answers
    task automatic test_single_root();
        write_node_count(1);
        send_req(tlca_pkg::REQ_NOP, 11'd1024, 11'd1024, 11'd1024);
        send_req(tlca_pkg::REQ_QUERY, 11'd0, 11'd0, 11'd1);
        send_req(tlca_pkg::REQ_LOAD, 11'd0, 11'd1, 11'd1);
        send_req(tlca_pkg::REQ_LOAD, 11'd2, 11'd1, 11'd2);
        send_req(tlca_pkg::REQ_LOAD, tlca_pkg::ROOT_NODE, 11'd0, 11'd1);
        send_req(tlca_pkg::REQ_BUILD, 11'd0, 11'd0, 11'd1);
        send_req(tlca_pkg::REQ_QUERY, tlca_pkg::ROOT_NODE, tlca_pkg::ROOT_NODE, 11'd1);
        send_req(tlca_pkg::REQ_QUERY, tlca_pkg::ROOT_NODE, 11'd2, 11'd1);
        send_req(tlca_pkg::REQ_QUERY, 11'd1024, tlca_pkg::ROOT_NODE, 11'd1);
    endtask

    // Four nodes with a bad root parent and one inconsistent maximum depth
    task automatic test_small_known_tree();
        write_node_count(4);
        send_req(tlca_pkg::REQ_LOAD, 11'd1, 11'd1024, 11'd1);
        send_req(tlca_pkg::REQ_LOAD, 11'd2, 11'd1, 11'd2);
        send_req(tlca_pkg::REQ_LOAD, 11'd3, 11'd2, 11'd3);
        send_req(tlca_pkg::REQ_LOAD, 11'd4, 11'd1, 11'd1024);
        send_req(tlca_pkg::REQ_BUILD, 11'd0, 11'd0, 11'd1);
        send_req(tlca_pkg::REQ_QUERY, 11'd3, 11'd4, 11'd1);
        send_req(tlca_pkg::REQ_QUERY, 11'd4, 11'd3, 11'd1);
        send_req(tlca_pkg::REQ_QUERY, 11'd3, 11'd2, 11'd1);
        send_req(tlca_pkg::REQ_QUERY, 11'd2, 11'd3, 11'd1);
        send_req(tlca_pkg::REQ_QUERY, 11'd3, 11'd3, 11'd1);
        send_req(tlca_pkg::REQ_QUERY, 11'd1, 11'd3, 11'd1);
        send_req(tlca_pkg::REQ_QUERY, 11'd4, 11'd4, 11'd1);
    endtask

    // Full-size deep tree, including the highest node id
    task automatic test_full_size_tree();
        run_tree_phase(MAX_N, SHAPE_CHAIN, 20);
        send_req(tlca_pkg::REQ_QUERY, 11'd1024, tlca_pkg::ROOT_NODE, any_depth());
        send_req(tlca_pkg::REQ_QUERY, tlca_pkg::ROOT_NODE, 11'd1024, any_depth());
        send_req(tlca_pkg::REQ_QUERY, 11'd1024, 11'd1024, any_depth());
        send_req(tlca_pkg::REQ_QUERY, 11'd1024, in_node(MAX_N), any_depth());
        send_req(tlca_pkg::REQ_LOAD, 11'd0, 11'd1024, 11'd1024);
    endtask

    // Receiver holds off for a long stretch while queries keep coming
    task automatic test_output_backpressure();
        run_tree_phase(8, SHAPE_RANDOM, 0);
        long_hold_req = 1'b1;
        for (int i = 0; i < 10; i++)
            send_req(tlca_pkg::REQ_QUERY, in_node(8), in_node(8), any_depth());
        wait_until_idle();
    endtask

    // Random trees of random size; a last tree runs without idling
    task automatic test_random_trees();
        int base, n, sel;
        base = work_items;
        while (work_items - base < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 9);
            if (sel == 0)      n = 1;
            else if (sel == 1) n = $urandom_range(33, 128);
            else               n = $urandom_range(2, 32);
            run_tree_phase(n, $urandom_range(SHAPE_RANDOM, SHAPE_HEAP), $urandom_range(4, 16));
        end
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_tree_phase($urandom_range(8, 24), SHAPE_RANDOM, 16);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold on request
    // ------------------------------------------------------------------
    initial begin : ready_driver
        int held;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                m_axis_tready <= 1'b0;
                held = 0;
                while (held < LONG_HOLD) begin
                    @(posedge i_clk);
                    held++;
                end
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest expected answer
    always @(posedge i_clk) begin : check_results
        t_answer want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[22:0];
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result transfer, data %h", $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_answers.pop_front();
                if (got.lca != want.lca) begin
                    $display("%0t: lca_node expected %0d actual %0d",
                             $time, want.lca, got.lca);
                    mismatch_count++;
                end
                if (got.path_len != want.path_len) begin
                    $display("%0t: path_length expected %0d actual %0d",
                             $time, want.path_len, got.path_len);
                    mismatch_count++;
                end
                if (got.on_path != want.on_path) begin
                    $display("%0t: on_root_path expected %0d actual %0d",
                             $time, want.on_path, got.on_path);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transfer for %0d cycles, %0d answers outstanding",
                 $time, WATCHDOG_LIMIT, pending_answers.size());
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_sequence
        for (int n = 0; n <= MAX_N; n++) begin
            depth_table[n] = '0;
            for (int l = 0; l < LIFT_LEVELS; l++) lift_table[n][l] = '0;
        end
        node_count_mdl = tlca_pkg::NODE_COUNT_RST;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= tlca_pkg::REQ_NOP;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_root();
        test_small_known_tree();
        test_full_size_tree();
        test_output_backpressure();
        test_random_trees();

        // Drain, then allow time for any stray result
        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_answers.size() != 0) begin
            $display("%0t: %0d expected answers never arrived", $time, pending_answers.size());
            mismatch_count++;
        end

        $display("Run covered %0d loads, %0d builds, %0d queries and %0d no-ops",
                 load_count, build_count, query_count, nop_count);
        $display("over %0d node-count settings up to %0d nodes; %0d mismatches",
                 settings_seen, largest_count, mismatch_count);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
